// ===== rtl/core/u8cp_pkg.sv =====
package u8cp_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;
  localparam int unsigned ByteW = 8;

  // Code points with a fixed fallback byte, checked before the table.
  localparam logic [CpW-1:0]   CpBrokenBar = 21'h0000A6;
  localparam logic [ByteW-1:0] ChBrokenBar = 8'h7C;
  localparam logic [CpW-1:0]   CpSection   = 21'h0000A7;
  localparam logic [ByteW-1:0] ChSection   = 8'h15;
  localparam logic [CpW-1:0]   CpPilcrow   = 21'h0000B6;
  localparam logic [ByteW-1:0] ChPilcrow   = 8'h14;
  localparam logic [CpW-1:0]   CpATilde    = 21'h0000E3;
  localparam logic [ByteW-1:0] ChATilde    = 8'h83;

  // Number of continuation bytes announced by each lead form.
  localparam logic [PendW-1:0] PendTwoByte   = 2'd1;
  localparam logic [PendW-1:0] PendThreeByte = 2'd2;
  localparam logic [PendW-1:0] PendFourByte  = 2'd3;

  localparam int unsigned UpperN = 128;

  // Unicode code point for each byte of the upper half, 0x80 upward.
  localparam logic [15:0] UpperHalf [UpperN] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // What one decode step produces for the output register.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] out_char;
    logic             end_of_string;
  } u8cp_res_t;

endpackage

// ===== rtl/core/u8cp_in_if.sv =====
interface u8cp_in_if;
  import u8cp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/u8cp_out_if.sv =====
interface u8cp_out_if;
  import u8cp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             end_of_string;

  modport source (output valid, output out_char, output end_of_string, input ready);
  modport sink (input valid, input out_char, input end_of_string, output ready);
endinterface

// ===== rtl/core/u8cp_map.sv =====
module u8cp_map
  import u8cp_pkg::*;
(
  input  logic [CpW-1:0]   cp_i,
  output logic [ByteW-1:0] char_o
);

  logic [ByteW-1:0] table_hit;

  // Walk downward so the lowest matching byte wins.
  always_comb begin
    table_hit = '0;
    for (int k = UpperN - 1; k >= 0; k--) begin
      if (cp_i == {5'b0, UpperHalf[k]}) begin
        table_hit = ByteW'(UpperN + k);
      end
    end
  end

  always_comb begin
    if (cp_i < CpW'(UpperN)) begin
      char_o = cp_i[ByteW-1:0];
    end else if (cp_i == CpBrokenBar) begin
      char_o = ChBrokenBar;
    end else if (cp_i == CpSection) begin
      char_o = ChSection;
    end else if (cp_i == CpPilcrow) begin
      char_o = ChPilcrow;
    end else if (cp_i == CpATilde) begin
      char_o = ChATilde;
    end else begin
      char_o = table_hit;
    end
  end

endmodule

// ===== rtl/core/u8cp_dec.sv =====
module u8cp_dec
  import u8cp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output u8cp_res_t        res_o
);

  logic [CpW-1:0]   cp_q, cp_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   cp_next;
  logic [ByteW-1:0] mapped;

  assign cp_next = {cp_q[CpW-7:0], byte_i[5:0]};

  u8cp_map u_map (
    .cp_i  (cp_next),
    .char_o(mapped)
  );

  always_comb begin
    cp_d   = '0;
    pend_d = '0;
    res_o  = '0;
    if (byte_i == '0) begin
      // Terminator: pending sequence is abandoned and the end marker goes out.
      res_o.emit          = 1'b1;
      res_o.end_of_string = 1'b1;
    end else if (pend_q != '0 && byte_i[7:6] == 2'b10) begin
      pend_d = pend_q - PendW'(1);
      if (pend_q == PendW'(1)) begin
        res_o.emit     = (mapped != '0);
        res_o.out_char = mapped;
      end else begin
        cp_d = cp_next;
      end
    end else begin
      // Lead byte, including one that breaks a pending sequence.
      if (byte_i[7] == 1'b0) begin
        res_o.emit     = 1'b1;
        res_o.out_char = byte_i;
      end else if (byte_i[7:5] == 3'b110) begin
        cp_d   = CpW'(byte_i[4:0]);
        pend_d = PendTwoByte;
      end else if (byte_i[7:4] == 4'b1110) begin
        cp_d   = CpW'(byte_i[3:0]);
        pend_d = PendThreeByte;
      end else if (byte_i[7:3] == 5'b11110) begin
        cp_d   = CpW'(byte_i[2:0]);
        pend_d = PendFourByte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q   <= '0;
      pend_q <= '0;
    end else if (step_i) begin
      cp_q   <= cp_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== rtl/core/utf8_to_cp437_decoder_core.sv =====
// UTF-8 to code page 437 transcoder.
//
// in_i carries one UTF-8 byte per word; out_o carries one CP437 character
// per word, or the end marker (out_char zero, end_of_string high) that a
// zero input byte produces. Both channels move a word when valid and ready
// are high at a rising edge. Bytes that complete nothing, invalid lead bytes
// and code points without a CP437 equivalent produce no output word.
//
// A byte is captured in an input register, then decoded and mapped against
// the partial code point once the output register can take a word, and lands
// in the output register. The decode and the 128-entry table compare are
// combinational logic between the two registers, so one byte is accepted
// per cycle for as long as out_o keeps up.
//
// When out_o stalls with a word held, the input register can still hold one
// more byte; in_i.ready then drops until the output register empties.
// Reset empties both registers and clears the partial code point and the
// count of pending continuation bytes.
module utf8_to_cp437_decoder_core
  import u8cp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  u8cp_in_if.sink     in_i,
  u8cp_out_if.source  out_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_char_q;
  logic             out_eos_q;
  logic             step;
  u8cp_res_t        res;

  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  u8cp_dec u_dec (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= res.emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
    if (step && res.emit) begin
      out_char_q <= res.out_char;
      out_eos_q  <= res.end_of_string;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.end_of_string = out_eos_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import u8cp_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned IdlePercent = 36;
  localparam int unsigned RandomBytes = 1250;
  localparam int unsigned MaxPrinted  = 40;

  // Continuation counts announced by the three lead forms.
  localparam logic [1:0] ContAfterTwo   = 2'd1;
  localparam logic [1:0] ContAfterThree = 2'd2;
  localparam logic [1:0] ContAfterFour  = 2'd3;

  localparam logic [7:0] OpeningBytes [28] = '{
    8'h41, 8'h7F,
    8'hC2, 8'hA6, 8'hC2, 8'hA7, 8'hC2, 8'hB6, 8'hC3, 8'hA3,
    8'hC3, 8'h87,
    8'hE2, 8'h96, 8'h91,
    8'hF0, 8'h80, 8'h81, 8'h81,
    8'h80, 8'hFF,
    8'hC3, 8'h41,
    8'hC0, 8'h80,
    8'hE2, 8'h00,
    8'h00
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } cp437_word_t;

  typedef logic [7:0] byte_q_t [$];

  class Cp437Scoreboard;
    cp437_word_t awaited [$];
    logic [20:0] code_acc;
    logic [1:0]  cont_left;
    logic [15:0] glyph_cp [128];
    int          errors;

    function new();
      code_acc  = '0;
      cont_left = '0;
      errors    = 0;
      glyph_cp = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
      };
    endfunction

    function void queue_word(logic [7:0] ch, logic eos);
      cp437_word_t w;
      w.ch  = ch;
      w.eos = eos;
      awaited.insert(awaited.size(), w);
    endfunction

    function logic [7:0] to_cp437(logic [20:0] cp);
      if (cp < 21'h80) return cp[7:0];
      case (cp)
        21'h0000A6: return 8'h7C;
        21'h0000A7: return 8'h15;
        21'h0000B6: return 8'h14;
        21'h0000E3: return 8'h83;
        default: ;
      endcase
      // The lowest matching byte wins.
      for (int k = 0; k < 128; k++) begin
        if ({5'b0, glyph_cp[k]} == cp) return 8'h80 + 8'(k);
      end
      return 8'h00;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] mapped;
      if (b == 8'h00) begin
        code_acc  = '0;
        cont_left = '0;
        queue_word(8'h00, 1'b1);
        return;
      end
      if (cont_left != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          code_acc  = {code_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            mapped   = to_cp437(code_acc);
            code_acc = '0;
            if (mapped != 8'h00) queue_word(mapped, 1'b0);
          end
          return;
        end
        // A broken sequence is dropped and this byte starts over as a lead.
        code_acc  = '0;
        cont_left = '0;
      end
      if (!b[7]) begin
        queue_word(b, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        code_acc  = {16'b0, b[4:0]};
        cont_left = ContAfterTwo;
      end else if (b[7:4] == 4'b1110) begin
        code_acc  = {17'b0, b[3:0]};
        cont_left = ContAfterThree;
      end else if (b[7:3] == 5'b11110) begin
        code_acc  = {18'b0, b[2:0]};
        cont_left = ContAfterFour;
      end
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [7:0] ch, logic eos);
      cp437_word_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word char=%02h eos=%0b", ch, eos));
        return;
      end
      want = awaited.pop_front();
      if (ch !== want.ch) report($sformatf("out_char %02h, expected %02h", ch, want.ch));
      if (eos !== want.eos) report($sformatf("end_of_string %0b, expected %0b", eos, want.eos));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  u8cp_in_if  in_if ();
  u8cp_out_if out_if ();

  Cp437Scoreboard sb = new();
  bit             calm;
  bit             hold_off;
  int unsigned    cycles;
  int unsigned    sent;

  utf8_to_cp437_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_byte(in_if.in_byte);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_word(out_if.out_char, out_if.end_of_string);
    end
  end

  // Receiver: random back-pressure, or one long hold-off when asked.
  initial begin
    forever begin
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
        @(posedge clk_i);
      end
    end
  end

  task send_byte(logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  function byte_q_t utf8_bytes(logic [20:0] cp, int len);
    byte_q_t q;
    case (len)
      1: q = '{{1'b0, cp[6:0]}};
      2: q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      3: q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      default: q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                     {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    endcase
    return q;
  endfunction

  task send_code(logic [20:0] cp);
    byte_q_t q;
    int      len;
    if (cp < 21'h80) len = 1;
    else if (cp < 21'h800) len = 2;
    else if (cp < 21'h10000) len = 3;
    else len = 4;
    // Now and then an overlong form of the same value.
    if (len < 4 && $urandom_range(0, 9) == 0) len++;
    q = utf8_bytes(cp, len);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // A lead followed by too few continuations and then a byte that breaks it.
  task send_broken();
    byte_q_t    q;
    int         len;
    int         keep;
    logic [7:0] breaker;
    len  = $urandom_range(2, 4);
    q    = utf8_bytes(21'($urandom()), len);
    keep = $urandom_range(1, len - 1);
    for (int i = 0; i < keep; i++) send_byte(q[i]);
    do breaker = 8'($urandom_range(0, 255)); while (breaker[7:6] == 2'b10);
    send_byte(breaker);
  endtask

  initial begin
    int unsigned pick;
    int unsigned step;
    bit          held;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    calm     = 1'b0;
    hold_off = 1'b0;
    held     = 1'b0;
    step     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OpeningBytes[i]) send_byte(OpeningBytes[i]);

    while (sent < RandomBytes + $size(OpeningBytes)) begin
      step++;
      calm = (step >= 250 && step < 400);
      if (!held && step == 550) begin
        // The sender keeps offering while the receiver holds off, so the
        // block fills and drops its input ready.
        held     = 1'b1;
        hold_off = 1'b1;
        repeat (30) send_byte(8'($urandom_range(1, 127)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) send_code(21'($urandom_range(1, 127)));
      else if (pick < 50) send_code({5'b0, sb.glyph_cp[$urandom_range(0, 127)]});
      else if (pick < 58) begin
        case ($urandom_range(0, 3))
          0: send_code(21'h0000A6);
          1: send_code(21'h0000A7);
          2: send_code(21'h0000B6);
          default: send_code(21'h0000E3);
        endcase
      end else if (pick < 64) send_code(21'($urandom_range(32'h80, 32'h7FF)));
      else if (pick < 70) send_code(21'($urandom_range(32'h800, 32'hFFFF)));
      else if (pick < 75) send_code(21'($urandom_range(32'h10000, 32'h1FFFFF)));
      else if (pick < 81) send_byte(8'h00);
      else if (pick < 90) send_byte(8'($urandom_range(0, 255)));
      else send_broken();
    end
    in_if.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
